// File: rtl/core/tun_pkg.sv
package tun_pkg;

  // default field widths
  localparam int COORD_WIDTH_DEF   = 16;
  localparam int OUT_FRAC_BITS_DEF = 16;

  // length floor register
  localparam int              MIN_LEN_WIDTH = 35;
  localparam logic [34:0]     MIN_LEN_RESET = 35'd167772;  // 0.01 in Q.24

  // root and quotient bits resolved per pipeline stage
  localparam int SQRT_STEPS = 2;
  localparam int DIV_STEPS  = 2;

endpackage

// File: rtl/core/tun_cross.sv
module tun_cross #(
  parameter int CW = tun_pkg::COORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  valid_i,
  input  logic signed [CW-1:0]  a_i [3],
  input  logic signed [CW-1:0]  b_i [3],
  input  logic signed [CW-1:0]  c_i [3],
  output logic                  valid_o,
  output logic signed [2*CW+2:0] n_o [3]
);

  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int NW = PW + 1;

  logic [2:0]           vld_r;
  logic signed [DW-1:0] eu_r [3];
  logic signed [DW-1:0] ev_r [3];
  logic signed [PW-1:0] pp_r [3];
  logic signed [PW-1:0] pm_r [3];
  logic signed [NW-1:0] n_r  [3];

  // valid bits follow the three stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], valid_i};
    end
  end

  // edges, partial products, cross product
  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    always_ff @(posedge clk) begin
      if (en) begin
        eu_r[i] <= DW'(a_i[i]) - DW'(b_i[i]);
        ev_r[i] <= DW'(b_i[i]) - DW'(c_i[i]);
        pp_r[i] <= PW'(eu_r[J]) * PW'(ev_r[K]);
        pm_r[i] <= PW'(eu_r[K]) * PW'(ev_r[J]);
        n_r[i]  <= NW'(pp_r[i]) - NW'(pm_r[i]);
      end
    end
  end

  assign valid_o = vld_r[2];
  assign n_o     = n_r;

endmodule

// File: rtl/core/tun_square.sv
module tun_square #(
  parameter int CW = tun_pkg::COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   valid_i,
  input  logic signed [2*CW+2:0] n_i [3],
  output logic                   valid_o,
  output logic [4*CW+3:0]        sum_o,
  output logic [2*CW+1:0]        mag_o [3],
  output logic                   neg_o [3]
);

  localparam int NW = 2 * CW + 3;
  localparam int MW = 2 * CW + 2;
  localparam int HL = (MW + 1) / 2;
  localparam int HH = MW - HL;
  localparam int SW = 2 * MW;

  logic [3:0]         vld_r;
  logic [MW-1:0]      mag_r [4][3];
  logic               neg_r [4][3];
  logic [2*HH-1:0]    hh_r  [3];
  logic [HH+HL-1:0]   hl_r  [3];
  logic [2*HL-1:0]    ll_r  [3];
  logic [SW-1:0]      sq_r  [3];
  logic [SW-1:0]      sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], valid_i};
    end
  end

  // magnitude, split square over halves, recombine
  for (genvar i = 0; i < 3; i++) begin : g_lane
    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[0][i] <= n_i[i][NW-1];
        mag_r[0][i] <= MW'(n_i[i][NW-1] ? -n_i[i] : n_i[i]);
        hh_r[i] <= (2*HH)'(mag_r[0][i][MW-1:HL]) * (2*HH)'(mag_r[0][i][MW-1:HL]);
        hl_r[i] <= (HH+HL)'(mag_r[0][i][MW-1:HL]) * (HH+HL)'(mag_r[0][i][HL-1:0]);
        ll_r[i] <= (2*HL)'(mag_r[0][i][HL-1:0]) * (2*HL)'(mag_r[0][i][HL-1:0]);
        sq_r[i] <= (SW'(hh_r[i]) << (2*HL)) + (SW'(hl_r[i]) << (HL+1)) + SW'(ll_r[i]);
        mag_r[1][i] <= mag_r[0][i];
        mag_r[2][i] <= mag_r[1][i];
        mag_r[3][i] <= mag_r[2][i];
        neg_r[1][i] <= neg_r[0][i];
        neg_r[2][i] <= neg_r[1][i];
        neg_r[3][i] <= neg_r[2][i];
      end
    end
    assign mag_o[i] = mag_r[3][i];
    assign neg_o[i] = neg_r[3][i];
  end

  // sum of squares; fits 2*MW bits
  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sq_r[0] + sq_r[1] + sq_r[2];
    end
  end

  assign valid_o = vld_r[3];
  assign sum_o   = sum_r;

endmodule

// File: rtl/core/tun_sqrt.sv
module tun_sqrt #(
  parameter int RW = 2 * tun_pkg::COORD_WIDTH_DEF + 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            valid_i,
  input  logic [2*RW-1:0] rad_i,
  input  logic [RW-1:0]   mag_i [3],
  input  logic            neg_i [3],
  output logic            valid_o,
  output logic [RW-1:0]   root_o,
  output logic [RW-1:0]   mag_o [3],
  output logic            neg_o [3]
);

  localparam int SW   = 2 * RW;
  localparam int SPS  = tun_pkg::SQRT_STEPS;
  localparam int NS   = (RW + SPS - 1) / SPS;
  localparam int REMW = RW + 3;

  logic [NS-1:0]   vld_r;
  logic [SW-1:0]   rad_r  [NS];
  logic [REMW-1:0] rem_r  [NS];
  logic [RW-1:0]   root_r [NS];
  logic [RW-1:0]   mag_r  [NS][3];
  logic            neg_r  [NS][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], valid_i};
    end
  end

  // digit-by-digit root, SPS result bits per stage
  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [SW-1:0]   rad_src;
    logic [REMW-1:0] rem_src;
    logic [RW-1:0]   root_src;
    logic [RW-1:0]   mag_src [3];
    logic            neg_src [3];
    logic [SW-1:0]   rad_c;
    logic [REMW-1:0] rem_c;
    logic [RW-1:0]   root_c;
    logic [REMW-1:0] trial_c;

    if (s == 0) begin : g_first
      assign rad_src  = rad_i;
      assign rem_src  = '0;
      assign root_src = '0;
      assign mag_src  = mag_i;
      assign neg_src  = neg_i;
    end else begin : g_next
      assign rad_src  = rad_r[s-1];
      assign rem_src  = rem_r[s-1];
      assign root_src = root_r[s-1];
      assign mag_src  = mag_r[s-1];
      assign neg_src  = neg_r[s-1];
    end

    always_comb begin
      rad_c   = rad_src;
      rem_c   = rem_src;
      root_c  = root_src;
      trial_c = '0;
      for (int k = 0; k < SPS; k++) begin
        if (s * SPS + k < RW) begin
          rem_c   = {rem_c[REMW-3:0], rad_c[SW-1 -: 2]};
          rad_c   = rad_c << 2;
          trial_c = REMW'({root_c, 2'b01});
          if (rem_c >= trial_c) begin
            rem_c  = rem_c - trial_c;
            root_c = {root_c[RW-2:0], 1'b1};
          end else begin
            root_c = {root_c[RW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[s]  <= rad_c;
        rem_r[s]  <= rem_c;
        root_r[s] <= root_c;
        mag_r[s]  <= mag_src;
        neg_r[s]  <= neg_src;
      end
    end
  end

  assign valid_o = vld_r[NS-1];
  assign root_o  = root_r[NS-1];
  assign mag_o   = mag_r[NS-1];
  assign neg_o   = neg_r[NS-1];

endmodule

// File: rtl/core/tun_div.sv
module tun_div #(
  parameter int RW  = 2 * tun_pkg::COORD_WIDTH_DEF + 2,
  parameter int OFB = tun_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               valid_i,
  input  logic [RW-1:0]                      root_i,
  input  logic [tun_pkg::MIN_LEN_WIDTH-1:0]  min_len_i,
  input  logic [RW-1:0]                      mag_i [3],
  input  logic                               neg_i [3],
  output logic                               valid_o,
  output logic [OFB:0]                       q_o [3],
  output logic                               neg_o [3]
);

  localparam int MLW = tun_pkg::MIN_LEN_WIDTH;
  localparam int LW  = (RW > MLW) ? RW : MLW;
  localparam int QW  = OFB + 1;
  localparam int TOT = OFB + 1;
  localparam int SPS = tun_pkg::DIV_STEPS;
  localparam int NS  = (TOT + SPS - 1) / SPS;

  logic [NS:0]     vld_r;
  logic [LW-1:0]   len_r [NS+1];
  logic [LW:0]     rem_r [NS+1][3];
  logic [QW-1:0]   q_r   [NS+1][3];
  logic            neg_r [NS+1][3];
  logic [LW-1:0]   root_ext;
  logic [LW-1:0]   ml_ext;
  logic [LW-1:0]   len_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-1:0], valid_i};
    end
  end

  // divisor: root raised to the floor, never zero
  always_comb begin
    root_ext = LW'(root_i);
    ml_ext   = LW'(min_len_i);
    len_c    = (root_ext < ml_ext) ? ml_ext : root_ext;
    if (len_c == '0) begin
      len_c = LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_r[0] <= len_c;
      for (int i = 0; i < 3; i++) begin
        rem_r[0][i] <= (LW+1)'(mag_i[i]);
        q_r[0][i]   <= '0;
        neg_r[0][i] <= neg_i[i];
      end
    end
  end

  // restoring division, SPS quotient bits per stage; first bit is the integer bit
  for (genvar s = 1; s <= NS; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        len_r[s] <= len_r[s-1];
      end
    end
    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [LW:0]   rem_c;
      logic [QW-1:0] q_c;

      always_comb begin
        rem_c = rem_r[s-1][i];
        q_c   = q_r[s-1][i];
        for (int k = 0; k < SPS; k++) begin
          if ((s - 1) * SPS + k < TOT) begin
            if ((s - 1) * SPS + k != 0) begin
              rem_c = {rem_c[LW-1:0], 1'b0};
            end
            if (rem_c >= {1'b0, len_r[s-1]}) begin
              rem_c = rem_c - {1'b0, len_r[s-1]};
              q_c   = {q_c[QW-2:0], 1'b1};
            end else begin
              q_c   = {q_c[QW-2:0], 1'b0};
            end
          end
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s][i] <= rem_c;
          q_r[s][i]   <= q_c;
          neg_r[s][i] <= neg_r[s-1][i];
        end
      end
    end
  end

  assign valid_o = vld_r[NS];
  assign q_o     = q_r[NS];
  assign neg_o   = neg_r[NS];

endmodule

// File: rtl/core/triangle_unit_normal_core.sv
// Unit face normal of a triangle. Each request carries vertices A, B, C in signed
// Q4.12; the result is (A-B) x (B-C) divided by its length, as signed Q1.16 clamped
// to one unit. Lengths below cfg_min_length (Q.24 cross-product units, reset 0.01)
// are raised to it, so a degenerate triangle gives a zero normal. The pipeline takes
// one request per clock while the skid entry is free. The square root resolves
// two root bits per stage and the divider two quotient bits per stage, and those
// two chains set the depth. A one-entry skid behind the output register keeps the
// input open while a result waits; once the skid fills, the input and the pipeline
// stall. Write cfg_min_length only when idle.
module triangle_unit_normal_core #(
  parameter int COORD_WIDTH   = tun_pkg::COORD_WIDTH_DEF,
  parameter int OUT_FRAC_BITS = tun_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_WIDTH-1:0]       in_a_x,
  input  logic signed [COORD_WIDTH-1:0]       in_a_y,
  input  logic signed [COORD_WIDTH-1:0]       in_a_z,
  input  logic signed [COORD_WIDTH-1:0]       in_b_x,
  input  logic signed [COORD_WIDTH-1:0]       in_b_y,
  input  logic signed [COORD_WIDTH-1:0]       in_b_z,
  input  logic signed [COORD_WIDTH-1:0]       in_c_x,
  input  logic signed [COORD_WIDTH-1:0]       in_c_y,
  input  logic signed [COORD_WIDTH-1:0]       in_c_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [OUT_FRAC_BITS+1:0]     out_unit_x,
  output logic signed [OUT_FRAC_BITS+1:0]     out_unit_y,
  output logic signed [OUT_FRAC_BITS+1:0]     out_unit_z,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tun_pkg::MIN_LEN_WIDTH-1:0]   cfg_min_length
);

  localparam int CW  = COORD_WIDTH;
  localparam int OFB = OUT_FRAC_BITS;
  localparam int RW  = 2 * CW + 2;
  localparam int QW  = OFB + 1;
  localparam int OW  = OFB + 2;
  localparam logic [QW-1:0] ONE = {1'b1, {OFB{1'b0}}};

  logic [tun_pkg::MIN_LEN_WIDTH-1:0] min_length_r;
  logic                   en;
  logic signed [CW-1:0]   a_v [3];
  logic signed [CW-1:0]   b_v [3];
  logic signed [CW-1:0]   c_v [3];
  logic                   crs_valid;
  logic signed [2*CW+2:0] crs_n [3];
  logic                   sq_valid;
  logic [2*RW-1:0]        sq_sum;
  logic [RW-1:0]          sq_mag [3];
  logic                   sq_neg [3];
  logic                   rt_valid;
  logic [RW-1:0]          rt_root;
  logic [RW-1:0]          rt_mag [3];
  logic                   rt_neg [3];
  logic                   div_valid;
  logic [QW-1:0]          div_q [3];
  logic                   div_neg [3];
  logic signed [OW-1:0]   unit_nxt [3];
  logic                   out_valid_r;
  logic signed [OW-1:0]   out_unit_r [3];
  logic                   skid_valid_r;
  logic signed [OW-1:0]   skid_unit_r [3];

  // length floor register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_length_r <= tun_pkg::MIN_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_length_r <= cfg_min_length;
    end
  end

  // whole pipeline advances while the skid entry is free
  assign en       = !skid_valid_r;
  assign in_ready = en;

  assign a_v[0] = in_a_x;
  assign a_v[1] = in_a_y;
  assign a_v[2] = in_a_z;
  assign b_v[0] = in_b_x;
  assign b_v[1] = in_b_y;
  assign b_v[2] = in_b_z;
  assign c_v[0] = in_c_x;
  assign c_v[1] = in_c_y;
  assign c_v[2] = in_c_z;

  tun_cross #(.CW(CW)) u_cross (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_valid),
    .a_i     (a_v),
    .b_i     (b_v),
    .c_i     (c_v),
    .valid_o (crs_valid),
    .n_o     (crs_n)
  );

  tun_square #(.CW(CW)) u_square (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (crs_valid),
    .n_i     (crs_n),
    .valid_o (sq_valid),
    .sum_o   (sq_sum),
    .mag_o   (sq_mag),
    .neg_o   (sq_neg)
  );

  tun_sqrt #(.RW(RW)) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (sq_valid),
    .rad_i   (sq_sum),
    .mag_i   (sq_mag),
    .neg_i   (sq_neg),
    .valid_o (rt_valid),
    .root_o  (rt_root),
    .mag_o   (rt_mag),
    .neg_o   (rt_neg)
  );

  tun_div #(.RW(RW), .OFB(OFB)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_i   (rt_valid),
    .root_i    (rt_root),
    .min_len_i (min_length_r),
    .mag_i     (rt_mag),
    .neg_i     (rt_neg),
    .valid_o   (div_valid),
    .q_o       (div_q),
    .neg_o     (div_neg)
  );

  // clamp to one unit and apply sign
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unit_nxt[i] = OW'((div_q[i] > ONE) ? ONE : div_q[i]);
      if (div_neg[i]) begin
        unit_nxt[i] = -unit_nxt[i];
      end
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && out_ready) begin
      if (skid_valid_r) begin
        out_unit_r   <= skid_unit_r;
        skid_valid_r <= 1'b0;
      end else if (div_valid) begin
        out_unit_r   <= unit_nxt;
      end else begin
        out_valid_r  <= 1'b0;
      end
    end else if (!out_valid_r) begin
      if (en && div_valid) begin
        out_unit_r  <= unit_nxt;
        out_valid_r <= 1'b1;
      end
    end else if (en && div_valid) begin
      skid_unit_r  <= unit_nxt;
      skid_valid_r <= 1'b1;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_unit_x = out_unit_r[0];
  assign out_unit_y = out_unit_r[1];
  assign out_unit_z = out_unit_r[2];

  // skid entry only holds a request behind a full output register
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid with empty output register");

  // skid fills only when the output was stalled
  a_skid_fill : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_ready))
    else $error("skid entry filled without an output stall");

  // divisor never below the vector magnitude, so quotients stay within one unit
  a_quot_range : assert property (@(posedge clk) disable iff (!rst_n)
    div_valid |-> (div_q[0] <= ONE) && (div_q[1] <= ONE) && (div_q[2] <= ONE))
    else $error("quotient above one unit");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

// Scoreboard for face normals: predicts each accepted request, checks results in order
class normal_scoreboard;
  logic [34:0] floor_len;
  logic [17:0] exp_x[$], exp_y[$], exp_z[$];
  int errors;
  int checked;

  function new();
    floor_len = tun_pkg::MIN_LEN_RESET;
    errors = 0;
    checked = 0;
  endfunction

  // magnitude/len truncated to Q1.16, clamped to one unit, then signed
  function logic [17:0] unit_of(longint c, logic [63:0] len);
    logic [63:0] mag;
    logic [127:0] q;
    logic [17:0] r;
    mag = (c < 0) ? -c : c;
    q = ({64'd0, mag} << 16) / {64'd0, len};
    if (q > 128'd65536) q = 128'd65536;
    r = q[17:0];
    if (c < 0) r = -r;
    return r;
  endfunction

  function void note_request(logic signed [15:0] v[9]);
    longint ux, uy, uz, vx, vy, vz, nx, ny, nz;
    logic signed [127:0] wx, wy, wz;
    logic [127:0] sum;
    logic [63:0] len, trial;
    ux = v[0] - v[3]; uy = v[1] - v[4]; uz = v[2] - v[5];
    vx = v[3] - v[6]; vy = v[4] - v[7]; vz = v[5] - v[8];
    nx = uy * vz - uz * vy;
    ny = uz * vx - ux * vz;
    nz = ux * vy - uy * vx;
    // squares exceed 64 bits near the coordinate extremes
    wx = nx; wy = ny; wz = nz;
    sum = wx * wx + wy * wy + wz * wz;
    len = 0;
    for (int b = 63; b >= 0; b--) begin
      trial = len | (64'd1 << b);
      if (128'(trial) * 128'(trial) <= sum) len = trial;
    end
    if (len < {29'd0, floor_len}) len = {29'd0, floor_len};
    if (len == 0) len = 1;
    exp_x.push_back(unit_of(nx, len));
    exp_y.push_back(unit_of(ny, len));
    exp_z.push_back(unit_of(nz, len));
  endfunction

  function int pending();
    return exp_x.size();
  endfunction
endclass

module tb;
  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  logic signed [15:0] in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z;
  logic signed [15:0] in_c_x, in_c_y, in_c_z;
  logic signed [17:0] out_unit_x, out_unit_y, out_unit_z;
  logic [34:0] cfg_min_length;

  normal_scoreboard sb;
  int send_idle, recv_stall;
  int cycles;
  int sent;
  localparam int LIMIT = 400000;
  localparam int LATENCY = 35;

  triangle_unit_normal_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_z(in_a_z),
    .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_z(in_b_z),
    .in_c_x(in_c_x), .in_c_y(in_c_y), .in_c_z(in_c_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_unit_x(out_unit_x), .out_unit_y(out_unit_y), .out_unit_z(out_unit_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_min_length(cfg_min_length)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // one line per mismatch
  task automatic report(string what, logic [17:0] got, logic [17:0] want);
    $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
    sb.errors++;
  endtask

  // result checker and random receiver stall
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (sb.pending() == 0) begin
        $display("mismatch: result with no request pending");
        sb.errors++;
      end else begin
        if (out_unit_x !== sb.exp_x[0]) report("unit_x", out_unit_x, sb.exp_x[0]);
        if (out_unit_y !== sb.exp_y[0]) report("unit_y", out_unit_y, sb.exp_y[0]);
        if (out_unit_z !== sb.exp_z[0]) report("unit_z", out_unit_z, sb.exp_z[0]);
        void'(sb.exp_x.pop_front());
        void'(sb.exp_y.pop_front());
        void'(sb.exp_z.pop_front());
        sb.checked++;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("triangle_unit_normal_core regression: fail");
      $finish;
    end
  end

  // valid stays high between back-to-back requests; dropped only for idle cycles
  task automatic send(logic signed [15:0] v[9]);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1;
    {in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z, in_c_x, in_c_y, in_c_z} <=
      {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
    do @(posedge clk); while (!in_ready);
    sb.note_request(v);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_floor(logic [34:0] val);
    drain();
    cfg_valid <= 1;
    cfg_min_length <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.floor_len = val;
    cfg_valid <= 0;
  endtask

  // coordinates: full range half the time, otherwise extremes or small values
  function automatic logic signed [15:0] rnd_coord();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(64)) - 16'sd32;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_batch(int n);
    logic signed [15:0] v[9];
    for (int k = 0; k < n; k++) begin
      for (int j = 0; j < 9; j++) v[j] = rnd_coord();
      // some collinear or repeated vertices
      if ($urandom_range(9) == 0) begin
        v[6] = v[3]; v[7] = v[4]; v[8] = v[5];
      end
      send(v);
    end
  endtask

  logic signed [15:0] d[9];
  logic [34:0] floors[6];

  initial begin
    sb = new();
    rst_n = 0; in_valid = 0; out_ready = 0; cfg_valid = 0; cfg_min_length = 0;
    {in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z, in_c_x, in_c_y, in_c_z} = '0;
    send_idle = 0; recv_stall = 0; cycles = 0; sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: degenerate, unit axis triangles, extremes, tiny triangle below floor
    d = '{default: 0}; send(d);
    d = '{16'sd4096, 0, 0, 0, 0, 0, 0, 16'sd4096, 0}; send(d);
    d = '{0, 16'sd4096, 0, 0, 0, 0, 0, 0, 16'sd4096}; send(d);
    d = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
          16'sh7fff, 16'sh8000, 16'sh7fff}; send(d);
    d = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
          16'sh8000, 16'sh8000, 16'sh7fff}; send(d);
    d = '{16'sd1, 0, 0, 0, 0, 0, 0, 16'sd1, 0}; send(d);
    d = '{16'sd5, 16'sd3, 0, 0, 0, 0, 0, 16'sd7, 0}; send(d);
    d = '{16'sh7fff, 0, 0, 0, 0, 0, 0, 16'sh8000, 0}; send(d);
    d = '{16'sd100, 16'sd100, 16'sd100, 16'sd200, 16'sd200, 16'sd200,
          16'sd300, 16'sd300, 16'sd300}; send(d);
    d = '{-16'sd1, -16'sd1, -16'sd1, 0, 0, 0, 16'sd1, -16'sd1, 16'sd1}; send(d);

    // floor settings, extremes included; zero floor too
    floors = '{35'd1, 35'h7_ffff_ffff, 35'd0, 35'd167772, 35'd4096, 35'd1 << 34};
    foreach (floors[f]) begin
      write_floor(floors[f]);
      d = '{default: 0}; send(d);
      d = '{16'sd1, 0, 0, 0, 0, 0, 0, 16'sd1, 0}; send(d);
      case (f % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 77; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 77; end
        default: begin send_idle = 17; recv_stall = 17; end
      endcase
      random_batch(40);
    end

    // pause until the pipe empties, then keep going on default floor
    write_floor(tun_pkg::MIN_LEN_RESET);
    for (int p = 0; p < 4; p++) begin
      send_idle = (p == 1 || p == 3) ? (p == 1 ? 77 : 17) : 0;
      recv_stall = (p == 2) ? 77 : (p == 3 ? 17 : 0);
      random_batch(165);
      if (p == 1) begin
        in_valid <= 0;
        do @(posedge clk); while (sb.pending() != 0);
      end
    end

    drain();
    $display("covered %0d triangles over %0d floor settings, %0d results checked",
             sent, 8, sb.checked);
    $display("phases: free flow, sparse sender, stalling receiver, mixed gaps");
    if (sb.errors == 0) begin
      $display("triangle_unit_normal_core regression: pass");
    end else begin
      $display("triangle_unit_normal_core regression: fail");
    end
    $finish;
  end
endmodule
